FILE: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// shared codes and constants of the min tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

  // request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_PUSH_FULL  = 2'd1;
  localparam logic [1:0] STAT_POP_EMPTY  = 2'd2;

  // minimum reported by an empty stack
  localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;

  typedef logic [1:0]         req_type_t;
  typedef logic [1:0]         status_t;
  typedef logic signed [31:0] value_t;
  typedef logic [7:0]         depth_t;

endpackage

FILE: rtl/mts_req_if.sv
// ----------------------------------------------------------------------------
// mts_req_if
// request channel: operation code and value to push
// ----------------------------------------------------------------------------
interface mts_req_if;
  import mts_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  value_t    push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

FILE: rtl/mts_rsp_if.sv
// ----------------------------------------------------------------------------
// mts_rsp_if
// response channel: status, current minimum and depth
// ----------------------------------------------------------------------------
interface mts_rsp_if;
  import mts_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  min_value;
  depth_t  stack_depth;

  modport source (output valid, output status, output min_value, output stack_depth,
                  input ready);
  modport sink   (input valid, input status, input min_value, input stack_depth,
                  output ready);

endinterface

FILE: rtl/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// stack of signed 32-bit values with a constant time minimum
// ----------------------------------------------------------------------------
// Each request beat (push, pop or query; code 3 acts as a query) gives exactly
// one response beat carrying a status, the minimum of the held values after the
// operation (2147483647 when empty) and the depth masked to 8 bits. Values and
// running minima live in two rams of STACK_DEPTH entries; the top of each stack
// is also held in a register, so a push, a query, a dropped push and a refused
// pop load the response register as they are accepted, and a new request can be
// taken every cycle while the response is taken. A pop that removes a value goes
// through the fill state: the cycle it is accepted reads the entries below both
// tops, and the fill cycle loads the registered ram data into the top registers and
// the response register. A push to a full stack is dropped with status 1, a pop on
// an empty stack is ignored with status 2. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
  parameter int STACK_DEPTH = 128
) (
  input logic       clk,
  input logic       rst,
  mts_req_if.sink   req,
  mts_rsp_if.source rsp
);
  import mts_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FILL = 1'b1;

  logic          state;
  logic [CW-1:0] vcount;        // main stack depth
  logic [CW-1:0] mcount;        // minima stack depth
  value_t        value_top;     // copy of value ram entry vcount-1
  value_t        min_top;       // copy of minima ram entry mcount-1
  logic          reload_v;      // refresh value top from ram in fill
  logic          reload_m;      // refresh minima top from ram in fill

  logic    out_valid;
  status_t out_status;
  value_t  out_min;
  depth_t  out_depth;

  // ram ports
  logic          v_wr_en, m_wr_en, v_rd_en, m_rd_en;
  logic [AW-1:0] v_wr_addr, m_wr_addr, v_rd_addr, m_rd_addr;
  value_t        v_rd_data, m_rd_data;

  // decode of the current beat
  logic          in_fire;
  logic          is_push, is_pop;
  logic          full, empty;
  logic          push_ok, push_min;
  logic          pop_ok, pop_min;
  logic [CW-1:0] vcount_dec, mcount_dec;

  // one request at a time; response register must be free or draining
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign in_fire   = req.valid && req.ready;

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    case (req.req_type)
      REQ_PUSH: is_push = 1'b1;
      REQ_POP:  is_pop  = 1'b1;
      default:  ; // query and unused code change nothing
    endcase
  end

  assign full       = (vcount == CW'(STACK_DEPTH));
  assign empty      = (vcount == '0);
  assign vcount_dec = vcount - 1'b1;
  assign mcount_dec = mcount - 1'b1;

  // push goes onto minima stack when it is empty or value is not above its top
  assign push_ok  = in_fire && is_push && !full;
  assign push_min = push_ok && (mcount != CW'(STACK_DEPTH)) &&
                    ((mcount == '0) || (req.push_value <= min_top));

  // popped value is the cached top; minima pops on an exact match
  assign pop_ok  = in_fire && is_pop && !empty;
  assign pop_min = pop_ok && (mcount != '0) && (value_top == min_top);

  // writes go to the slot just above each top
  assign v_wr_en   = push_ok;
  assign v_wr_addr = vcount[AW-1:0];
  assign m_wr_en   = push_min;
  assign m_wr_addr = mcount[AW-1:0];

  // a pop reads the entry below each top; data lands in the fill cycle
  assign v_rd_en   = pop_ok;
  assign v_rd_addr = AW'(vcount - CW'(2));
  assign m_rd_en   = pop_min;
  assign m_rd_addr = AW'(mcount - CW'(2));

  mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_value_ram (
    .clk     (clk),
    .wr_en   (v_wr_en),
    .wr_addr (v_wr_addr),
    .wr_data (req.push_value),
    .rd_en   (v_rd_en),
    .rd_addr (v_rd_addr),
    .rd_data (v_rd_data)
  );

  mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_minima_ram (
    .clk     (clk),
    .wr_en   (m_wr_en),
    .wr_addr (m_wr_addr),
    .wr_data (req.push_value),
    .rd_en   (m_rd_en),
    .rd_addr (m_rd_addr),
    .rd_data (m_rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcount    <= '0;
      mcount    <= '0;
      reload_v  <= 1'b0;
      reload_m  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (push_ok) begin
        vcount <= vcount + 1'b1;
      end else if (pop_ok) begin
        vcount <= vcount_dec;
      end
      if (push_min) begin
        mcount <= mcount + 1'b1;
      end else if (pop_min) begin
        mcount <= mcount_dec;
      end

      case (state)
        ST_IDLE: begin
          if (pop_ok) begin
            state    <= ST_FILL;
            reload_v <= (vcount_dec != '0);
            reload_m <= pop_min && (mcount_dec != '0);
          end
        end
        ST_FILL: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      // response register: loaded by a finished beat, cleared when taken
      if ((in_fire && !pop_ok) || (state == ST_FILL)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // top caches and response payload
  always_ff @(posedge clk) begin
    if (push_ok) begin
      value_top <= req.push_value;
    end else if ((state == ST_FILL) && reload_v) begin
      value_top <= v_rd_data;
    end
    if (push_min) begin
      min_top <= req.push_value;
    end else if ((state == ST_FILL) && reload_m) begin
      min_top <= m_rd_data;
    end

    if (in_fire && !pop_ok) begin
      if (is_push && full) begin
        out_status <= STAT_PUSH_FULL;
      end else if (is_pop) begin
        out_status <= STAT_POP_EMPTY;
      end else begin
        out_status <= STAT_OK;
      end
      if (push_min) begin
        out_min <= req.push_value;
      end else if (mcount == '0) begin
        out_min <= EMPTY_MIN;
      end else begin
        out_min <= min_top;
      end
      out_depth <= depth_t'(push_ok ? vcount + 1'b1 : vcount);
    end else if (state == ST_FILL) begin
      out_status <= STAT_OK;
      if (mcount == '0) begin
        out_min <= EMPTY_MIN;
      end else if (reload_m) begin
        out_min <= m_rd_data;
      end else begin
        out_min <= min_top;
      end
      out_depth <= depth_t'(vcount);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.min_value   = out_min;
  assign rsp.stack_depth = out_depth;

  // minima stack never outgrows the main stack
  a_counts_order: assert property (@(posedge clk) disable iff (rst)
    mcount <= vcount)
    else $error("minima count above value count");

  // value count stays within the ram
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vcount <= CW'(STACK_DEPTH))
    else $error("value count beyond stack depth");

  // a removing pop goes to fill and its response follows right after
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> (state == ST_FILL) ##1 rsp.valid)
    else $error("pop did not complete through fill");

  // cached minimum never exceeds cached top while both are current
  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && (mcount != '0)) |-> (min_top <= value_top))
    else $error("cached minimum above cached top");

endmodule

FILE: rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the min tracking stack
// ----------------------------------------------------------------------------
// Request beats are driven with random gaps. Response beats are taken with
// random stalls. A scoreboard object predicts status, minimum and depth
// for every accepted request and checks each response beat in order. A short
// directed part covers the value extremes, every request code, duplicate minima
// and a pop on an empty stack. Random fill, drain and mixed runs then take the
// stack to full and back many times.
// ----------------------------------------------------------------------------
module tb_top;
  import mts_pkg::*;

  localparam int DEPTH          = 128;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int QUIET_TAIL     = 200;    // last beats run with no idling
  localparam int LONG_HOLD      = 80;     // cycles the receiver holds off once
  localparam int WATCHDOG_LIMIT = 1000;   // cycles with no beat on either side

  // request code 3 has no name in the package; the block treats it as a query
  localparam req_type_t REQ_UNUSED = 2'd3;

  localparam value_t VAL_MIN = 32'sh8000_0000;
  localparam value_t VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum {FILL_UP, DRAIN_DOWN, MIXED} run_mode_t;

  typedef struct packed {
    status_t status;
    value_t  min_value;
    depth_t  stack_depth;
  } rsp_beat_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of both stacks, queue of predicted response beats
  // --------------------------------------------------------------------------
  class min_stack_scoreboard;
    value_t    values [DEPTH];
    value_t    minima [DEPTH];
    int        held     = 0;
    int        min_held = 0;
    rsp_beat_t predicted [$];
    int        errors   = 0;
    int        n_push   = 0;
    int        n_pop    = 0;
    int        n_query  = 0;
    int        n_full   = 0;
    int        n_empty  = 0;
    int        peak     = 0;

    function int pending();
      return predicted.size();
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // apply one accepted request to the model and queue its response
    function void note_request(req_type_t op, value_t v);
      rsp_beat_t beat;
      beat.status = STAT_OK;
      case (op)
        REQ_PUSH: begin
          n_push++;
          if (held >= DEPTH) begin
            beat.status = STAT_PUSH_FULL;
            n_full++;
          end else begin
            values[held] = v;
            held++;
            // equal values are stacked too, so duplicate minima survive a pop
            if (min_held == 0 || v <= minima[min_held-1]) begin
              if (min_held < DEPTH) begin
                minima[min_held] = v;
                min_held++;
              end
            end
          end
        end
        REQ_POP: begin
          n_pop++;
          if (held == 0) begin
            beat.status = STAT_POP_EMPTY;
            n_empty++;
          end else begin
            held--;
            if (min_held > 0 && values[held] == minima[min_held-1]) min_held--;
          end
        end
        default: n_query++;
      endcase
      if (held > peak) peak = held;
      beat.min_value   = (min_held == 0) ? EMPTY_MIN : minima[min_held-1];
      beat.stack_depth = depth_t'(held);
      predicted.push_back(beat);
    endfunction

    task check_response(status_t st, value_t mv, depth_t dp);
      rsp_beat_t want;
      if (predicted.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing pending (status %0d)", st));
      end else begin
        want = predicted.pop_front();
        if (st !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", st, want.status));
        if (mv !== want.min_value)
          report_mismatch($sformatf("min_value %0d, want %0d", mv, want.min_value));
        if (dp !== want.stack_depth)
          report_mismatch($sformatf("stack_depth %0d, want %0d", dp, want.stack_depth));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mts_req_if req_ch ();
  mts_rsp_if rsp_ch ();

  min_tracking_stack_top #(.STACK_DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  min_stack_scoreboard sb;

  bit idle_on  = 1'b1;  // random gaps and stalls allowed
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off
  int watchdog = 0;

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled at the same edge the block sees them;
  // the request is noted first in case a response leaves in the same cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.req_type, req_ch.push_value);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.status, rsp_ch.min_value, rsp_ch.stack_depth);
    end
  end

  // watchdog: a run that stops moving ends as a failure
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: short random stalls, stall-free stretches, and one long hold-off
  // counted here while the sender keeps offering beats
  // --------------------------------------------------------------------------
  initial begin
    int r;
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 19);
      if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && r < 5) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else if (r == 19) begin
        // a stretch with no stalls at all
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------

  // offer one request beat, maybe after a short gap, and wait for it to go
  task automatic issue_request(input req_type_t op, input value_t v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= op;
    req_ch.push_value <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // lower valid and wait until every predicted response has been taken
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // mostly small values so equal minima are common, plus full range and extremes
  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return value_t'($signed($urandom_range(0, 16)) - 8);
    if (r < 7) return value_t'($urandom);
    if (r == 7) return VAL_MIN;
    if (r == 8) return VAL_MAX;
    return ($urandom_range(0, 1) == 0) ? value_t'(-1) : value_t'(0);
  endfunction

  function automatic req_type_t pick_op(run_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      FILL_UP: begin
        if (r < 88) return REQ_PUSH;
        if (r < 92) return REQ_POP;
        if (r < 96) return REQ_QUERY;
        return REQ_UNUSED;
      end
      DRAIN_DOWN: begin
        if (r < 88) return REQ_POP;
        if (r < 92) return REQ_PUSH;
        if (r < 96) return REQ_QUERY;
        return REQ_UNUSED;
      end
      default: begin
        if (r < 40) return REQ_PUSH;
        if (r < 75) return REQ_POP;
        if (r < 90) return REQ_QUERY;
        return REQ_UNUSED;
      end
    endcase
  endfunction

  initial begin
    int        sent;
    int        seg;
    int        len;
    bit        seg_idle;
    run_mode_t mode;

    sb = new();
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_QUERY;
    req_ch.push_value <= '0;
    rst               <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // empty stack: query, pop refused, unused code
    issue_request(REQ_QUERY, 32'sd0);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_UNUSED, value_t'($urandom));
    // largest value on an empty stack reads the same as the empty minimum
    issue_request(REQ_PUSH, VAL_MAX);
    issue_request(REQ_POP, 32'sd0);
    // extremes and a duplicate minimum
    issue_request(REQ_PUSH, 32'sd0);
    issue_request(REQ_PUSH, VAL_MAX);
    issue_request(REQ_PUSH, VAL_MIN);
    issue_request(REQ_PUSH, VAL_MIN);
    issue_request(REQ_PUSH, -32'sd1);
    issue_request(REQ_QUERY, value_t'($urandom));
    issue_request(REQ_UNUSED, VAL_MIN);
    // unwind: the duplicate keeps the minimum after the first pop of it
    issue_request(REQ_POP, value_t'($urandom));
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_POP, 32'sd0);
    // alternating bit patterns, one positive and one negative
    issue_request(REQ_PUSH, 32'sh5555_5555);
    issue_request(REQ_PUSH, 32'shAAAA_AAAA);
    issue_request(REQ_QUERY, 32'sh5555_5555);
    issue_request(REQ_POP, 32'shAAAA_AAAA);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_POP, 32'sd0);

    // ---- random part: fill, drain and mixed runs ----
    sent = 0;
    seg  = 0;
    while (sent < RANDOM_ITEMS) begin
      // first run always fills so the full case comes early
      if (seg == 0) mode = FILL_UP;
      else mode = run_mode_t'($urandom_range(0, 4) < 2 ? $urandom_range(0, 1) : 2);
      len      = (mode == MIXED) ? $urandom_range(10, 60) : $urandom_range(140, 180);
      seg_idle = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        idle_on = seg_idle && (sent < RANDOM_ITEMS - QUIET_TAIL);
        // receiver holds off while the stack is filling, so the block backs up
        if (seg == 0 && i == 30) hold_req = 1'b1;
        // sender pauses once with every response taken
        if (sent == RANDOM_ITEMS / 2) wait_drained();
        issue_request(pick_op(mode), pick_value());
        sent++;
      end
      seg++;
    end

    // ---- end of run ----
    idle_on = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("tb_top: %0d pushes, %0d pops, %0d queries over %0d runs, peak depth %0d",
             sb.n_push, sb.n_pop, sb.n_query, seg, sb.peak);
    $display("tb_top: %0d pushes dropped when full, %0d pops refused when empty",
             sb.n_full, sb.n_empty);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches", sb.errors);
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
